/* sv/mf_pkg.sv */
// Package: shared constants, types and the lightness function for the median filter.
package mf_pkg;

  localparam int WINDOW   = 3;
  localparam int HIST     = WINDOW - 1;
  localparam int NWIN     = WINDOW * WINDOW;
  localparam int MED_RANK = NWIN / 2;
  localparam int RANK_W   = $clog2(NWIN);
  localparam int LINE_MAX = 1024;
  localparam int AW       = $clog2(LINE_MAX);
  localparam int LW_W     = 11;
  localparam int LW_RESET = 640;
  localparam int ROW_W    = 11;
  localparam int ROW_SAT  = 2047;

  // pixel packed {red, green, blue}
  typedef logic [23:0] pix_t;
  typedef logic [7:0]  lum_t;

  typedef struct packed {
    logic [WINDOW-1:0][23:0] pix;
    logic [WINDOW-1:0][7:0]  lum;
  } col_t;

  typedef logic [HIST-1:0][23:0] lb_word_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
  } lb_ctl_t;

  function automatic lum_t lightness(input pix_t p);
    logic [7:0] r, g, b, mx, mn;
    logic [8:0] s;
    r  = p[23:16];
    g  = p[15:8];
    b  = p[7:0];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    s  = {1'b0, mx} + {1'b0, mn};
    return s[8:1];
  endfunction

endpackage

/* sv/mf_cell.sv */
// Window cell: holds one window column and loads the column on its d input on each shift.
module mf_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  mf_pkg::col_t d,
  output mf_pkg::col_t q
);

  mf_pkg::col_t q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* sv/mf_lbuf.sv */
// Line buffer: one word per column holding the previous lines, with clear pass and bypass.
module mf_lbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  mf_pkg::lb_ctl_t     ctl,
  input  mf_pkg::pix_t        wr_pix,
  output mf_pkg::lb_word_t    rd_word,
  output logic                clr_done
);

  mf_pkg::lb_word_t mem [mf_pkg::LINE_MAX];
  mf_pkg::lb_word_t mem_q_r;
  mf_pkg::lb_word_t byp_q_r;
  logic             byp_r;
  mf_pkg::lb_word_t wr_word;
  logic [mf_pkg::AW-1:0] clr_cnt_r;
  logic             clr_done_r;

  assign rd_word = byp_r ? byp_q_r : mem_q_r;

  always_comb begin
    for (int r = 0; r < mf_pkg::HIST - 1; r++) begin
      wr_word[r] = rd_word[r+1];
    end
    wr_word[mf_pkg::HIST-1] = wr_pix;
  end

  always_ff @(posedge clk) begin
    if (!clr_done_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[ctl.rd_addr];
      byp_q_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_done_r <= 1'b1;
        end
      end
      if (ctl.rd_en) begin
        byp_r <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
      end
    end
  end

  assign clr_done = clr_done_r;

endmodule

/* sv/mf_rank.sv */
// Rank stage: ranks window pixels by lightness and selects the middle-rank pixel.
module mf_rank (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic          in_last,
  input  mf_pkg::col_t  win [mf_pkg::WINDOW],
  output logic          out_valid,
  output logic          out_last,
  output mf_pkg::pix_t  med
);

  mf_pkg::pix_t pix      [mf_pkg::NWIN];
  mf_pkg::lum_t lum      [mf_pkg::NWIN];
  logic [mf_pkg::RANK_W-1:0] cnt [mf_pkg::NWIN];
  logic [mf_pkg::NWIN-1:0]   sel_nxt;
  logic [mf_pkg::NWIN-1:0]   sel_r;
  mf_pkg::pix_t pix_r    [mf_pkg::NWIN];
  logic         valid_r;
  logic         last_r;

  // scan order: columns left to right, rows top to bottom
  always_comb begin
    for (int c = 0; c < mf_pkg::WINDOW; c++) begin
      for (int r = 0; r < mf_pkg::WINDOW; r++) begin
        pix[c*mf_pkg::WINDOW + r] = win[c].pix[r];
        lum[c*mf_pkg::WINDOW + r] = win[c].lum[r];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < mf_pkg::NWIN; k++) begin
      cnt[k] = '0;
      for (int m = 0; m < mf_pkg::NWIN; m++) begin
        if ((lum[m] < lum[k]) || ((lum[m] == lum[k]) && (m < k))) begin
          cnt[k] = cnt[k] + 1'b1;
        end
      end
      sel_nxt[k] = (cnt[k] == mf_pkg::RANK_W'(mf_pkg::MED_RANK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r  <= sel_nxt;
      last_r <= in_last;
      for (int k = 0; k < mf_pkg::NWIN; k++) begin
        pix_r[k] <= pix[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_comb begin
    med = '0;
    for (int k = 0; k < mf_pkg::NWIN; k++) begin
      med = med | (pix_r[k] & {24{sel_r[k]}});
    end
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $onehot(sel_r))
    else $error("median select not one-hot");

endmodule

/* sv/median_filter_by_lightness.sv */
// Top level: 3x3 median filter by lightness over a raster RGB pixel stream.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------------
//   in_     | in  | in_tvalid/in_tready | tdata red,green,blue; tuser frame_start
//   out_    | out | out_tvalid/out_tready | tdata red,green,blue; tlast row_end
//   cfg_    | in  | cfg_wr_en           | cfg_wr_data line_width
//
// One pixel per clock sustained while out_tready keeps the output register free.
// Stages: line buffer read, window cell shift, rank compare, select into output register.
// After reset the line buffer is cleared one column per cycle (all LINE_MAX = 1024 columns),
// with in_tready low; cfg writes are taken meanwhile.
// A result held with out_tready low freezes the whole pipeline; in_tready follows the
// output register.
module median_filter_by_lightness (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  in_tuser,   // frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic                  out_tlast,  // row_end
  input  logic                  cfg_wr_en,
  input  logic [mf_pkg::LW_W-1:0] cfg_wr_data
);

  logic en, acc, clr_done;

  logic [mf_pkg::LW_W-1:0]  line_width_r;
  logic [mf_pkg::AW-1:0]    col_r, col_nxt, col_eff, wm1;
  logic [mf_pkg::ROW_W-1:0] row_r, row_nxt, row_eff;
  logic [31:0]              w32;
  logic                     last, emit;

  logic                  va_r, emit_a_r, last_a_r;
  logic [mf_pkg::AW-1:0] col_a_r;
  mf_pkg::pix_t          pix_a_r;
  logic                  vb_r, last_b_r;

  mf_pkg::lb_ctl_t  lb_ctl;
  mf_pkg::lb_word_t rd_word;
  mf_pkg::col_t     new_col;
  mf_pkg::col_t     cell_q [mf_pkg::WINDOW];

  logic         vc, lc;
  mf_pkg::pix_t med;

  logic         out_valid_r, out_last_r;
  mf_pkg::pix_t out_pix_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && clr_done;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    w32 = {{(32-mf_pkg::LW_W){1'b0}}, line_width_r};
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(mf_pkg::LINE_MAX)) begin
      w32 = 32'(mf_pkg::LINE_MAX);
    end
    wm1 = mf_pkg::AW'(w32 - 32'd1);
  end

  always_comb begin
    col_eff = in_tuser ? '0 : col_r;
    row_eff = in_tuser ? '0 : row_r;
    last    = (col_eff >= wm1);
    emit    = (row_eff >= mf_pkg::ROW_W'(mf_pkg::HIST)) &&
              (col_eff >= mf_pkg::AW'(mf_pkg::HIST));
    col_nxt = last ? '0 : col_eff + 1'b1;
    row_nxt = row_eff;
    if (last && (row_eff < mf_pkg::ROW_W'(mf_pkg::ROW_SAT))) begin
      row_nxt = row_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= mf_pkg::LW_W'(mf_pkg::LW_RESET);
      col_r        <= '0;
      row_r        <= '0;
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_width_r <= cfg_wr_data;
      end
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (en) begin
        va_r        <= acc;
        vb_r        <= va_r && emit_a_r;
        out_valid_r <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      col_a_r  <= col_eff;
      pix_a_r  <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      emit_a_r <= emit;
      last_a_r <= last;
    end
    if (en) begin
      last_b_r   <= last_a_r;
      out_pix_r  <= med;
      out_last_r <= lc;
    end
  end

  always_comb begin
    lb_ctl.rd_en   = acc;
    lb_ctl.rd_addr = col_eff;
    lb_ctl.wr_en   = en && va_r;
    lb_ctl.wr_addr = col_a_r;
  end

  mf_lbuf u_lbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lb_ctl),
    .wr_pix   (pix_a_r),
    .rd_word  (rd_word),
    .clr_done (clr_done)
  );

  always_comb begin
    for (int r = 0; r < mf_pkg::HIST; r++) begin
      new_col.pix[r] = rd_word[r];
    end
    new_col.pix[mf_pkg::WINDOW-1] = pix_a_r;
    for (int r = 0; r < mf_pkg::WINDOW; r++) begin
      new_col.lum[r] = mf_pkg::lightness(new_col.pix[r]);
    end
  end

  for (genvar i = 0; i < mf_pkg::WINDOW; i++) begin : g_cell
    mf_cell u_cell (
      .clk      (clk),
      .shift_en (en && va_r),
      .d        ((i == mf_pkg::WINDOW - 1) ? new_col : cell_q[(i + 1) % mf_pkg::WINDOW]),
      .q        (cell_q[i])
    );
  end

  mf_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vb_r),
    .in_last   (last_b_r),
    .win       (cell_q),
    .out_valid (vc),
    .out_last  (lc),
    .med       (med)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r[7:0], out_pix_r[15:8], out_pix_r[23:16]};
  assign out_tlast  = out_last_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !in_tready)
    else $error("beat accepted during line buffer clear");

  a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !en) |=> (va_r && $stable(col_a_r)))
    else $error("stage A lost a beat under stall");

  a_border_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && va_r && !emit_a_r) |=> !vb_r)
    else $error("border pixel entered the rank stage");

endmodule
